>>> rtl/cmcmm_pkg.sv
// Package: types and constants for the circular merge cost unit.
`timescale 1ns / 1ps
package cmcmm_pkg;

  localparam int unsigned MaxPilesDefault = 128;
  localparam int unsigned SizeW           = 16;
  localparam int unsigned PrefixW         = 25;
  localparam int unsigned CostW           = 32;
  localparam logic [CostW-1:0] CostSentinel = '1;

  typedef struct packed {
    logic [SizeW-1:0] pile_size;
    logic             last_pile;
  } pile_t;

  typedef struct packed {
    logic [CostW-1:0] min_cost;
    logic [CostW-1:0] max_cost;
    logic             overflow;
  } cost_t;

  typedef enum logic [3:0] {
    S_IDLE, S_INIT, S_P1, S_P2, S_P3, S_RA, S_RB, S_ACC, S_WR, S_FRD, S_FACC, S_DONE
  } state_e;

endpackage

>>> rtl/circular_merge_cost_min_max_unit.sv
// Top level: ring merge cost min/max solver over on-chip interval tables.
// Flow: after the last pile, the interval sequencer fills the cost tables by
// lengths through one read port per table, then reduces them to the result.
// Throughput: one pile per cycle while loading; busy holds off the next ring.
// Reset clears control state only; tables need no clearing. Results cannot stall.
`timescale 1ns / 1ps
module circular_merge_cost_min_max_unit
  import cmcmm_pkg::*;
#(
  parameter int unsigned MAX_PILES = MaxPilesDefault
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start,
  output logic  busy,
  input  pile_t item_i,
  output logic  done_o,
  output cost_t result_o
);

  localparam int unsigned IW = (MAX_PILES > 1) ? $clog2(MAX_PILES) : 1;
  localparam int unsigned CW = $clog2(MAX_PILES + 1);
  localparam int unsigned PW = CW;
  localparam int unsigned TD = 1 << (2 * IW);

  state_e state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d, n_q, n_d, len_q, len_d, j_q, j_d;
  logic [IW-1:0] st_q, st_d, rs_q, rs_d;
  logic [PrefixW-1:0] sum_q, sum_d, ps_q, ps_d, s_q, s_d;
  logic wrap_q, wrap_d, ovf_q, ovf_d, done_q, done_d;
  logic [CostW-1:0] mn_q, mn_d, mx_q, mx_d, amin_q, amin_d, amax_q, amax_d;
  cost_t res_q, res_d;

  logic [PrefixW-1:0] pre_mem [MAX_PILES+1];
  logic [PrefixW-1:0] pre_rd_q, pre_wdata;
  logic [PW-1:0] pre_waddr, pre_raddr;
  logic pre_we;

  logic [CostW-1:0] min_mem [TD];
  logic [CostW-1:0] max_mem [TD];
  logic [CostW-1:0] min_rd_q, max_rd_q, tbl_wmin, tbl_wmax;
  logic [2*IW-1:0] tbl_raddr, tbl_waddr;
  logic tbl_we;

  always_ff @(posedge clk_i) begin
    if (pre_we) pre_mem[pre_waddr] <= pre_wdata;
    pre_rd_q <= pre_mem[pre_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      min_mem[tbl_waddr] <= tbl_wmin;
      max_mem[tbl_waddr] <= tbl_wmax;
    end
    min_rd_q <= min_mem[tbl_raddr];
    max_rd_q <= max_mem[tbl_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      sum_q   <= '0;
      ovf_q   <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      sum_q   <= sum_d;
      ovf_q   <= ovf_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q <= n_d; len_q <= len_d; j_q <= j_d; st_q <= st_d; rs_q <= rs_d;
    ps_q <= ps_d; s_q <= s_d; wrap_q <= wrap_d;
    mn_q <= mn_d; mx_q <= mx_d; amin_q <= amin_d; amax_q <= amax_d;
    res_q <= res_d;
  end

  logic [CW:0] end_w, end_adj;
  logic [CostW+1:0] sa, sb;
  logic [CostW-1:0] ca, cb;
  logic last_st;
  logic [PrefixW-1:0] next_sum;

  always_comb begin
    state_d = state_q; cnt_d = cnt_q; n_d = n_q; len_d = len_q; j_d = j_q;
    st_d = st_q; rs_d = rs_q; sum_d = sum_q; ps_d = ps_q; s_d = s_q;
    wrap_d = wrap_q; ovf_d = ovf_q; done_d = 1'b0; mn_d = mn_q; mx_d = mx_q;
    amin_d = amin_q; amax_d = amax_q; res_d = res_q;
    pre_we = 1'b0; pre_waddr = '0; pre_wdata = '0; pre_raddr = '0;
    tbl_we = 1'b0; tbl_waddr = '0; tbl_wmin = '0; tbl_wmax = '0; tbl_raddr = '0;
    last_st = ((CW'(st_q) + CW'(1)) == n_q);
    next_sum = sum_q + PrefixW'(item_i.pile_size);
    end_w = (CW+1)'(st_q) + (CW+1)'(len_q);
    end_adj = (end_w > (CW+1)'(n_q)) ? end_w - (CW+1)'(n_q) : end_w;
    sa = (CostW+2)'(amin_q) + (CostW+2)'(min_rd_q) + (CostW+2)'(s_q);
    sb = (CostW+2)'(amax_q) + (CostW+2)'(max_rd_q) + (CostW+2)'(s_q);
    ca = (sa[CostW+1:CostW] != 2'b00) ? CostSentinel : sa[CostW-1:0];
    cb = (sb[CostW+1:CostW] != 2'b00) ? CostSentinel : sb[CostW-1:0];
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          if (cnt_q < CW'(MAX_PILES)) begin
            pre_we    = 1'b1;
            pre_waddr = PW'(cnt_q + CW'(1));
            pre_wdata = next_sum;
            sum_d     = next_sum;
            cnt_d     = cnt_q + CW'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (item_i.last_pile) begin
            n_d     = (cnt_q < CW'(MAX_PILES)) ? cnt_q + CW'(1) : cnt_q;
            st_d    = '0;
            state_d = S_INIT;
          end
        end
      end
      S_INIT: begin
        tbl_we    = 1'b1;
        tbl_waddr = {st_q, IW'(0)};
        if (last_st) begin
          st_d  = '0;
          len_d = CW'(2);
          mn_d  = CostSentinel;
          mx_d  = '0;
          state_d = (n_q == CW'(1)) ? S_FRD : S_P1;
        end else begin
          st_d = st_q + IW'(1);
        end
      end
      S_P1: begin
        pre_raddr = PW'(st_q);
        state_d   = S_P2;
      end
      S_P2: begin
        ps_d      = (st_q == '0) ? '0 : pre_rd_q;
        wrap_d    = (end_w > (CW+1)'(n_q));
        pre_raddr = PW'(end_adj);
        state_d   = S_P3;
      end
      S_P3: begin
        s_d  = wrap_q ? (sum_q - ps_q + pre_rd_q) : (pre_rd_q - ps_q);
        mn_d = CostSentinel;
        mx_d = '0;
        j_d  = CW'(1);
        rs_d = last_st ? '0 : st_q + IW'(1);
        state_d = S_RA;
      end
      S_RA: begin
        tbl_raddr = {st_q, IW'(j_q - CW'(1))};
        state_d   = S_RB;
      end
      S_RB: begin
        amin_d    = min_rd_q;
        amax_d    = max_rd_q;
        tbl_raddr = {rs_q, IW'(len_q - j_q - CW'(1))};
        state_d   = S_ACC;
      end
      S_ACC: begin
        if (ca < mn_q) mn_d = ca;
        if (cb > mx_q) mx_d = cb;
        j_d  = j_q + CW'(1);
        rs_d = ((CW'(rs_q) + CW'(1)) == n_q) ? '0 : rs_q + IW'(1);
        state_d = ((j_q + CW'(1)) == len_q) ? S_WR : S_RA;
      end
      S_WR: begin
        tbl_we    = 1'b1;
        tbl_waddr = {st_q, IW'(len_q - CW'(1))};
        tbl_wmin  = mn_q;
        tbl_wmax  = mx_q;
        if (last_st) begin
          st_d = '0;
          if (len_q == n_q) begin
            mn_d    = CostSentinel;
            mx_d    = '0;
            state_d = S_FRD;
          end else begin
            len_d   = len_q + CW'(1);
            state_d = S_P1;
          end
        end else begin
          st_d    = st_q + IW'(1);
          state_d = S_P1;
        end
      end
      S_FRD: begin
        tbl_raddr = {st_q, IW'(n_q - CW'(1))};
        state_d   = S_FACC;
      end
      S_FACC: begin
        if (min_rd_q < mn_q) mn_d = min_rd_q;
        if (max_rd_q > mx_q) mx_d = max_rd_q;
        if (last_st) begin
          res_d.min_cost = (min_rd_q < mn_q) ? min_rd_q : mn_q;
          res_d.max_cost = (max_rd_q > mx_q) ? max_rd_q : mx_q;
          res_d.overflow = ovf_q;
          done_d  = 1'b1;
          state_d = S_DONE;
        end else begin
          st_d    = st_q + IW'(1);
          state_d = S_FRD;
        end
      end
      S_DONE: begin
        cnt_d   = '0;
        sum_d   = '0;
        ovf_d   = 1'b0;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign busy     = (state_q != S_IDLE);
  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

>>> tb/tb_circular_merge_cost_min_max_unit.sv
// Testbench: ring merge cost min/max unit checked against a cycle-free cost model.
`timescale 1ns / 1ps
module tb_circular_merge_cost_min_max_unit;
  import cmcmm_pkg::*;

  localparam int unsigned Cap = 128;

  class ring_cost_board;
    longint unsigned ring_sizes[$];
    bit              ring_dropped;
    cost_t           cost_q[$];
    int              errors;
    int              rings_seen;
    int              results_seen;

    function cost_t solve_ring();
      longint unsigned pre[0:Cap];
      longint unsigned lo_t[0:Cap-1][0:Cap-1];
      longint unsigned hi_t[0:Cap-1][0:Cap-1];
      longint unsigned arc, a, b, mn, mx, best_lo, best_hi;
      int n, ln, st, j, rs, e;
      cost_t r;
      n = ring_sizes.size();
      pre[0] = 0;
      for (int i = 0; i < n; i++) pre[i+1] = pre[i] + ring_sizes[i];
      for (st = 0; st < n; st++) begin
        lo_t[st][0] = 0;
        hi_t[st][0] = 0;
      end
      for (ln = 2; ln <= n; ln++) begin
        for (st = 0; st < n; st++) begin
          e = st + ln;
          if (e <= n) arc = pre[e] - pre[st];
          else arc = pre[n] - pre[st] + pre[e-n];
          mn = 64'hFFFF_FFFF;
          mx = 0;
          for (j = 1; j < ln; j++) begin
            rs = (st + j) % n;
            a = lo_t[st][j-1] + lo_t[rs][ln-j-1] + arc;
            b = hi_t[st][j-1] + hi_t[rs][ln-j-1] + arc;
            if (a > 64'hFFFF_FFFF) a = 64'hFFFF_FFFF;
            if (b > 64'hFFFF_FFFF) b = 64'hFFFF_FFFF;
            if (a < mn) mn = a;
            if (b > mx) mx = b;
          end
          lo_t[st][ln-1] = mn;
          hi_t[st][ln-1] = mx;
        end
      end
      best_lo = 64'hFFFF_FFFF;
      best_hi = 0;
      for (st = 0; st < n; st++) begin
        if (lo_t[st][n-1] < best_lo) best_lo = lo_t[st][n-1];
        if (hi_t[st][n-1] > best_hi) best_hi = hi_t[st][n-1];
      end
      r.min_cost = best_lo[CostW-1:0];
      r.max_cost = best_hi[CostW-1:0];
      r.overflow = ring_dropped;
      return r;
    endfunction

    function void note_pile(pile_t p);
      if (ring_sizes.size() < Cap) ring_sizes.push_back(p.pile_size);
      else ring_dropped = 1'b1;
      if (p.last_pile) begin
        cost_q.push_back(solve_ring());
        ring_sizes.delete();
        ring_dropped = 1'b0;
        rings_seen++;
      end
    endfunction

    function void check(cost_t got);
      cost_t exp_c;
      results_seen++;
      if (cost_q.size() == 0) begin
        $error("result with no expected cost pending");
        errors++;
        return;
      end
      exp_c = cost_q.pop_front();
      if (got.min_cost !== exp_c.min_cost) begin
        $error("min_cost expected %0d actual %0d", exp_c.min_cost, got.min_cost);
        errors++;
      end
      if (got.max_cost !== exp_c.max_cost) begin
        $error("max_cost expected %0d actual %0d", exp_c.max_cost, got.max_cost);
        errors++;
      end
      if (got.overflow !== exp_c.overflow) begin
        $error("overflow expected %0b actual %0b", exp_c.overflow, got.overflow);
        errors++;
      end
    endfunction
  endclass

  logic  clk_i = 1'b0;
  logic  rst_ni;
  logic  start;
  logic  busy;
  pile_t item_i;
  logic  done_o;
  cost_t result_o;

  ring_cost_board board;
  int idle_pct;
  int piles_sent;

  circular_merge_cost_min_max_unit uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .item_i(item_i), .done_o(done_o), .result_o(result_o)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && done_o) board.check(result_o);
  end

  task automatic send_pile(input logic [SizeW-1:0] sz, input logic last);
    pile_t p;
    p.pile_size = sz;
    p.last_pile = last;
    start  <= 1'b1;
    item_i <= p;
    do @(posedge clk_i); while (busy);
    board.note_pile(p);
    piles_sent++;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk_i);
    end
  endtask

  task automatic send_ring(input int n, input int sz_mode);
    logic [SizeW-1:0] sz;
    for (int i = 0; i < n; i++) begin
      case (sz_mode)
        0: sz = SizeW'($urandom);
        1: sz = SizeW'($urandom_range(15));
        2: sz = '1;
        default: sz = '0;
      endcase
      send_pile(sz, i == n - 1);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (board.cost_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  initial begin
    #100_000_000;
    $display("FAIL circular_merge_cost_min_max_unit");
    $finish;
  end

  initial begin
    board = new();
    start = 1'b0;
    item_i = '0;
    rst_ni = 1'b0;
    idle_pct = 0;
    piles_sent = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: single piles, extremes, short rings, one overflowing ring
    send_pile('0, 1'b1);
    send_pile('1, 1'b1);
    send_ring(2, 2);
    send_ring(3, 3);
    send_pile(16'h0001, 1'b0);
    send_pile(16'hFFFF, 1'b0);
    send_pile(16'h8000, 1'b0);
    send_pile(16'h7FFF, 1'b1);
    send_ring(5, 2);
    drain();
    send_ring(Cap + 3, 0);
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 34 : (ph == 1) ? 68 : 0;
      for (int r = 0; r < 40; r++) begin
        send_ring($urandom_range(7, 1), $urandom_range(99) < 80 ? 0 : 1);
        if (r == 25) drain();
      end
    end
    drain();

    $display("Covered %0d piles in %0d rings, %0d results, incl. single-pile and overflow rings.",
             piles_sent, board.rings_seen, board.results_seen);
    if (board.errors == 0 && board.cost_q.size() == 0) begin
      $display("PASS circular_merge_cost_min_max_unit");
    end else begin
      $display("FAIL circular_merge_cost_min_max_unit");
    end
    $finish;
  end

endmodule
